// ===== hw/rtl/mffl_pkg.sv =====
// Shared types, constants and the frame verdict function of the message frame field locator.
`default_nettype none

package mffl_pkg;

	localparam int MAX_FRAME = 4096;
	localparam int MIN_FRAME = 13;

	// Byte offsets and counts up to MAX_FRAME, and size values up to MAX_FRAME + 1.
	localparam int POS_W = $clog2(MAX_FRAME + 1);
	localparam int VAL_W = $clog2(MAX_FRAME + 2);
	localparam int MUL_W = VAL_W + 4;

	// Result field widths are fixed by the output format.
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int OUT_W   = 104;

	localparam logic [7:0] CH_M   = 8'h4D;
	localparam logic [7:0] CH_S   = 8'h53;
	localparam logic [7:0] CH_G   = 8'h47;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;

	localparam logic [1:0] ST_VALID     = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;

	typedef enum logic [2:0] {
		PH_SKIP_SUBJ  = 3'd0,
		PH_SUBJ       = 3'd1,
		PH_SKIP_SID   = 3'd2,
		PH_SID        = 3'd3,
		PH_SKIP_REPLY = 3'd4,
		PH_REPLY      = 3'd5,
		PH_DONE       = 3'd6
	} scan_phase_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             sat;
		logic [POS_W-1:0] bpos;
		logic             after_blank;
	} run_t;

	typedef struct packed {
		logic             valid;
		logic             cr_before;
		logic [POS_W-1:0] pos;
		run_t             run;
	} nl_rec_t;

	// All frame state other than the scan phase; every field clears to zero.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             too_long;
		logic             kw_fail;
		logic [POS_W-1:0] subj_begin;
		logic [POS_W-1:0] subj_size;
		logic [POS_W-1:0] sid_begin;
		logic [POS_W-1:0] sid_size;
		logic [POS_W-1:0] third_begin;
		logic [POS_W-1:0] third_size;
		logic             third_seen;
		run_t             run;
		run_t             held;
		logic [7:0]       prev;
		nl_rec_t          nl0;
		nl_rec_t          nl1;
	} frame_t;

	typedef struct packed {
		frame_t      frame;
		scan_phase_t phase;
	} snap_t;

	// Ordered so that status lands in the lowest bits when packed.
	typedef struct packed {
		logic [LEN_W-1:0]   body_length;
		logic [START_W-1:0] body_offset;
		logic [LEN_W-1:0]   reply_length;
		logic [START_W-1:0] reply_offset;
		logic               reply_present;
		logic [LEN_W-1:0]   sid_len;
		logic [START_W-1:0] sid_offset;
		logic [LEN_W-1:0]   subj_length;
		logic [START_W-1:0] subj_offset;
		logic [1:0]         status;
	} res_t;

	function automatic res_t mffl_eval(snap_t s);
		res_t             r;
		logic             ok;
		logic             phase_ok;
		logic [POS_W-1:0] plen;
		frame_t           f;
		f = s.frame;
		r = '0;
		phase_ok = (s.phase == PH_SKIP_REPLY) || (s.phase == PH_REPLY) || (s.phase == PH_DONE);
		plen = f.pos - POS_W'(3) - f.nl1.pos;
		ok = !f.kw_fail && (f.pos >= POS_W'(MIN_FRAME)) && phase_ok
			&& f.nl0.valid && ((f.nl0.pos + 1'b1) == f.pos) && f.nl0.cr_before
			&& f.nl1.valid && (f.nl1.pos != '0) && f.nl1.cr_before
			&& (((POS_W+1)'(f.nl1.pos) + (POS_W+1)'(3)) <= (POS_W+1)'(f.pos))
			&& f.nl1.run.after_blank && !f.nl1.run.sat
			&& ((POS_W+1)'(f.nl1.run.value) == (POS_W+1)'(plen));
		if (f.too_long) begin
			r.status = ST_TOO_LONG;
		end else if (!ok) begin
			r.status = ST_MALFORMED;
		end else begin
			r.status      = ST_VALID;
			r.subj_offset = START_W'(f.subj_begin);
			r.subj_length = LEN_W'(f.subj_size);
			r.sid_offset  = START_W'(f.sid_begin);
			r.sid_len     = LEN_W'(f.sid_size);
			if (f.third_seen && (f.third_begin < f.nl1.run.bpos)) begin
				r.reply_present = 1'b1;
				r.reply_offset  = START_W'(f.third_begin);
				if (s.phase == PH_REPLY) begin
					r.reply_length = LEN_W'(f.pos - f.third_begin);
				end else begin
					r.reply_length = LEN_W'(f.third_size);
				end
			end
			r.body_offset = START_W'(f.nl1.pos + 1'b1);
			r.body_length = LEN_W'(plen);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msg_frame_field_locator.sv =====
// Top level of the message frame field locator: input stage, frame snapshot and result register.
//
// Usage: a text message frame enters one byte per transfer on the slave stream, the final
// byte marked by s_tlast. For each frame one result transfer leaves on the master stream,
// carrying the status (valid, malformed, or longer than MAX_FRAME) and the offset and length
// of the subject, sid, optional reply-to token and payload; every field but the status is
// zero unless the frame is valid.
// Throughput: one byte per cycle, sustained until a final byte finds no room downstream (see Stalls).
// The scanner updates its frame state from the registered input byte, so bytes flow back to back
// across frame borders. Result path: the final byte is registered in the input register, then
// in the frame snapshot register, then in the result register, which drives m_tvalid; a stall can
// hold it in any of these stages.
// Stalls: a result waiting on m_tready holds the result register; bytes inside a frame keep
// flowing regardless. A further frame end is parked in the snapshot stage, and only when
// both that stage and the result register are full does s_tready drop, on a final byte.
// Reset: arst_n clears all frame state and empties every stage; no clearing pass is needed,
// and the block accepts bytes as soon as reset is released.
`default_nettype none

module msg_frame_field_locator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,  // [7:0] data_byte
	input  logic                      s_tlast,  // last_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [1:0] status, [13:2] subj_offset, [26:14] subj_length, [38:27] sid_offset,
	// [51:39] sid_len, [52] reply_present, [64:53] reply_offset, [77:65] reply_length,
	// [89:78] body_offset, [102:90] body_length, [103] zero
	output logic [mffl_pkg::OUT_W-1:0] m_tdata
);
	import mffl_pkg::*;

	// Input register stage.
	logic       vld_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Snapshot of the frame state after its final byte.
	logic  vld_s2;
	snap_t snap_s2;

	// Result register.
	logic out_vld_q;
	res_t res_q;

	snap_t snap;
	logic  out_rdy;
	logic  s2_rdy;
	logic  adv1;

	// Only a final byte needs room downstream; any other byte is absorbed at once.
	assign out_rdy  = !out_vld_q || m_tready;
	assign s2_rdy   = !vld_s2 || out_rdy;
	assign adv1     = vld_s1 && (!last_s1 || s2_rdy);
	assign s_tready = !vld_s1 || adv1;

	mffl_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv1),
		.data_in (data_s1),
		.last_in (last_s1),
		.snap    (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_rdy) begin
			vld_s2 <= adv1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last_s1) begin
			snap_s2 <= snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_rdy) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && vld_s2) begin
			res_q <= mffl_eval(snap_s2);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, res_q};

	// The status code never takes the unused fourth value.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> ((res_q.status == ST_VALID) || (res_q.status == ST_MALFORMED)
			|| (res_q.status == ST_TOO_LONG)))
		else $error("result carries an undefined status code");

	// A frame that is not valid reports nothing but its status.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (res_q.status != ST_VALID)) |-> (m_tdata[OUT_W-1:2] == '0))
		else $error("fields of a rejected frame are not zero");

	// Without a reply-to token its offset and length stay zero.
	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !res_q.reply_present) |->
		((res_q.reply_offset == '0) && (res_q.reply_length == '0)))
		else $error("reply-to fields set while no reply-to token is present");

	// A valid payload and its closing CRLF lie inside the frame limit.
	a_payload_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (res_q.status == ST_VALID)) |->
		(((LEN_W+1)'(res_q.body_offset) + (LEN_W+1)'(res_q.body_length) + (LEN_W+1)'(2))
			<= (LEN_W+1)'(MAX_FRAME)))
		else $error("valid payload reaches past the frame limit");

endmodule

`default_nettype wire

// ===== hw/rtl/mffl_scan.sv =====
// Per-byte frame scanner: token boundaries, size digit runs and newline records.
`default_nettype none

module mffl_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      data_in,
	input  logic            last_in,
	output mffl_pkg::snap_t snap
);
	import mffl_pkg::*;

	frame_t      st_q;
	frame_t      st_n;
	scan_phase_t phase_q;
	scan_phase_t phase_n;

	logic             look;
	logic             scan_en;
	logic             blank;
	logic             digit;
	logic             prev_digit;
	logic             prev_blank;
	logic [MUL_W-1:0] prod;

	assign look       = st_q.pos < POS_W'(MAX_FRAME);
	assign scan_en    = look && (st_q.pos >= POS_W'(3));
	assign blank      = (data_in == CH_SP) || (data_in == CH_TAB);
	assign digit      = data_in inside {[CH_0:CH_9]};
	assign prev_digit = st_q.prev inside {[CH_0:CH_9]};
	assign prev_blank = (st_q.prev == CH_SP) || (st_q.prev == CH_TAB);
	assign prod       = MUL_W'(st_q.run.value) * MUL_W'(10) + MUL_W'(data_in[3:0]);

	// Token phase: alternates between skipping blanks and measuring a token.
	always_comb begin
		phase_n = phase_q;
		if (scan_en) begin
			case (phase_q)
				PH_SKIP_SUBJ:  if (!blank) phase_n = PH_SUBJ;
				PH_SUBJ:       if (blank) phase_n = PH_SKIP_SID;
				PH_SKIP_SID:   if (!blank) phase_n = PH_SID;
				PH_SID:        if (blank) phase_n = PH_SKIP_REPLY;
				PH_SKIP_REPLY: if (!blank) phase_n = PH_REPLY;
				PH_REPLY:      if (blank) phase_n = PH_DONE;
				default:       phase_n = phase_q;
			endcase
		end
	end

	always_comb begin
		st_n = st_q;
		if (!look) begin
			st_n.too_long = 1'b1;
		end else begin
			st_n.pos = st_q.pos + 1'b1;
			if (((st_q.pos == POS_W'(0)) && (data_in != CH_M)) ||
			    ((st_q.pos == POS_W'(1)) && (data_in != CH_S)) ||
			    ((st_q.pos == POS_W'(2)) && (data_in != CH_G))) begin
				st_n.kw_fail = 1'b1;
			end
			if (scan_en) begin
				case (phase_q)
					PH_SKIP_SUBJ: if (!blank) st_n.subj_begin = st_q.pos;
					PH_SUBJ:      if (blank) st_n.subj_size = st_q.pos - st_q.subj_begin;
					PH_SKIP_SID:  if (!blank) st_n.sid_begin = st_q.pos;
					PH_SID:       if (blank) st_n.sid_size = st_q.pos - st_q.sid_begin;
					PH_SKIP_REPLY: begin
						if (!blank) begin
							st_n.third_begin = st_q.pos;
							st_n.third_seen  = 1'b1;
						end
					end
					PH_REPLY:     if (blank) st_n.third_size = st_q.pos - st_q.third_begin;
					default:      st_n.third_size = st_q.third_size;
				endcase
			end
			if (digit) begin
				if (prev_digit) begin
					if (!st_q.run.sat) begin
						if (prod > MUL_W'(MAX_FRAME)) begin
							st_n.run.sat   = 1'b1;
							st_n.run.value = VAL_W'(MAX_FRAME + 1);
						end else begin
							st_n.run.value = VAL_W'(prod);
						end
					end
				end else begin
					st_n.run.bpos        = st_q.pos;
					st_n.run.value       = VAL_W'(data_in[3:0]);
					st_n.run.sat         = 1'b0;
					st_n.run.after_blank = (st_q.pos >= POS_W'(2)) && prev_blank;
				end
			end
			if (data_in == CH_CR) begin
				if (prev_digit) begin
					st_n.held = st_q.run;
				end else begin
					st_n.held.value       = '0;
					st_n.held.sat         = 1'b0;
					st_n.held.bpos        = st_q.pos;
					st_n.held.after_blank = (st_q.pos >= POS_W'(2)) && prev_blank;
				end
			end
			if (data_in == CH_LF) begin
				st_n.nl1           = st_q.nl0;
				st_n.nl0.valid     = 1'b1;
				st_n.nl0.cr_before = st_q.prev == CH_CR;
				st_n.nl0.pos       = st_q.pos;
				st_n.nl0.run       = st_q.held;
			end
			st_n.prev = data_in;
		end
	end

	assign snap.frame = st_n;
	assign snap.phase = phase_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			phase_q <= PH_SKIP_SUBJ;
		end else if (advance) begin
			if (last_in) begin
				st_q    <= '0;
				phase_q <= PH_SKIP_SUBJ;
			end else begin
				st_q    <= st_n;
				phase_q <= phase_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb_msg_frame_field_locator.sv =====
// Self-checking testbench of the message frame field locator: framed byte stimulus and scoreboard.
`timescale 1ns / 100ps

module tb_msg_frame_field_locator;
	import mffl_pkg::*;

	// This many idle cycles in a row mean the block has hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Length of the deliberate hold-off on the result side.
	localparam int HOLD_CYCLES    = 600;

	typedef bit [POS_W-1:0] offs_t;

	// A run of decimal digits as the scanner tracks it.
	typedef struct packed {
		bit [VAL_W-1:0] value;
		bit             sat;
		offs_t          bpos;
		bit             after_blank;
	} digit_run_t;

	// What was known at one LF: where it sat, whether a CR came just before, and the size run.
	typedef struct packed {
		bit         valid;
		bit         cr_before;
		offs_t      pos;
		digit_run_t run;
	} lf_mark_t;

	typedef enum int {
		FR_GOOD,
		FR_BAD_KEYWORD,
		FR_BAD_SIZE,
		FR_SIZE_OVER,
		FR_NO_BLANK_SIZE,
		FR_NO_INNER_LF,
		FR_BAD_TAIL,
		FR_NO_SID,
		FR_LF_IN_PAYLOAD,
		FR_NOISE
	} frame_kind_t;

	// Tracks every byte that enters the block and predicts the field map of each frame.
	class field_map_scoreboard;
		offs_t       count;
		bit          overflow;
		scan_phase_t phase;
		bit          kw_ok;
		offs_t       subj_b, subj_n, sid_b, sid_n, rep_b, rep_n;
		bit          rep_seen;
		digit_run_t  digits;
		digit_run_t  held;
		logic [7:0]  prev;
		lf_mark_t    lf_last;
		lf_mark_t    lf_prev;
		res_t        awaited_maps[$];
		int          errors;

		function new();
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			count    = '0;
			overflow = 1'b0;
			phase    = PH_SKIP_SUBJ;
			kw_ok    = 1'b1;
			subj_b   = '0;
			subj_n   = '0;
			sid_b    = '0;
			sid_n    = '0;
			rep_b    = '0;
			rep_n    = '0;
			rep_seen = 1'b0;
			digits   = '0;
			held     = '0;
			prev     = '0;
			lf_last  = '0;
			lf_prev  = '0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return (c == CH_SP) || (c == CH_TAB);
		endfunction

		function bit is_digit(logic [7:0] c);
			return (c >= CH_0) && (c <= CH_9);
		endfunction

		// Updates the frame state with one byte at offset p.
		function void scan_byte(logic [7:0] c, offs_t p);
			bit blank;
			int d;
			int t;
			blank = is_blank(c);
			if ((p == 0 && c != CH_M) || (p == 1 && c != CH_S) || (p == 2 && c != CH_G))
				kw_ok = 1'b0;
			if (p >= 3) begin
				case (phase)
					PH_SKIP_SUBJ: if (!blank) begin subj_b = p; phase = PH_SUBJ; end
					PH_SUBJ: if (blank) begin subj_n = p - subj_b; phase = PH_SKIP_SID; end
					PH_SKIP_SID: if (!blank) begin sid_b = p; phase = PH_SID; end
					PH_SID: if (blank) begin sid_n = p - sid_b; phase = PH_SKIP_REPLY; end
					PH_SKIP_REPLY: if (!blank) begin
						rep_b    = p;
						rep_seen = 1'b1;
						phase    = PH_REPLY;
					end
					PH_REPLY: if (blank) begin rep_n = p - rep_b; phase = PH_DONE; end
					default: ;
				endcase
			end
			if (is_digit(c)) begin
				d = int'(c - CH_0);
				if (is_digit(prev)) begin
					// Once past MAX_FRAME the value sticks, so long runs cannot wrap round.
					if (!digits.sat) begin
						t = int'(digits.value) * 10 + d;
						if (t > MAX_FRAME) begin
							digits.sat   = 1'b1;
							digits.value = VAL_W'(MAX_FRAME + 1);
						end else begin
							digits.value = VAL_W'(t);
						end
					end
				end else begin
					digits.bpos        = p;
					digits.value       = VAL_W'(d);
					digits.sat         = 1'b0;
					digits.after_blank = (p >= 2) && is_blank(prev);
				end
			end
			if (c == CH_CR) begin
				if (is_digit(prev)) begin
					held = digits;
				end else begin
					// No digits before the CR: an empty size field that reads as zero.
					held.value       = '0;
					held.sat         = 1'b0;
					held.bpos        = p;
					held.after_blank = (p >= 2) && is_blank(prev);
				end
			end
			if (c == CH_LF) begin
				lf_prev           = lf_last;
				lf_last.valid     = 1'b1;
				lf_last.cr_before = (prev == CH_CR);
				lf_last.pos       = p;
				lf_last.run       = held;
			end
			prev = c;
		endfunction

		// Works out the result of the frame that has just ended.
		function res_t locate_fields();
			res_t        r;
			bit          ok;
			int unsigned sz;
			int unsigned plen;
			r  = '0;
			sz = count;
			if (overflow) begin
				r.status = ST_TOO_LONG;
			end else begin
				ok = kw_ok && (sz >= MIN_FRAME)
					&& (phase == PH_SKIP_REPLY || phase == PH_REPLY || phase == PH_DONE)
					&& lf_last.valid && (lf_last.pos + 1 == sz) && lf_last.cr_before
					&& lf_prev.valid && (lf_prev.pos > 0) && lf_prev.cr_before
					&& (lf_prev.pos + 3 <= sz);
				if (ok) begin
					plen = sz - 3 - lf_prev.pos;
					ok = lf_prev.run.after_blank && !lf_prev.run.sat
						&& (lf_prev.run.value == plen);
					if (ok) begin
						r.subj_offset = START_W'(subj_b);
						r.subj_length = LEN_W'(subj_n);
						r.sid_offset  = START_W'(sid_b);
						r.sid_len     = LEN_W'(sid_n);
						// A third token that is really the size field is not a reply-to.
						if (rep_seen && (rep_b < lf_prev.run.bpos)) begin
							r.reply_present = 1'b1;
							r.reply_offset  = START_W'(rep_b);
							r.reply_length  = (phase == PH_REPLY) ? LEN_W'(sz - rep_b)
								: LEN_W'(rep_n);
						end
						r.body_offset = START_W'(lf_prev.pos + 1);
						r.body_length = LEN_W'(plen);
					end
				end
				r.status = ok ? ST_VALID : ST_MALFORMED;
			end
			return r;
		endfunction

		// Called for each byte transfer into the block.
		function void note_byte(logic [7:0] c, logic last);
			// Bytes past MAX_FRAME are not looked at; they only mark the frame as too long.
			if (count >= MAX_FRAME) begin
				overflow = 1'b1;
			end else begin
				scan_byte(c, count);
				count++;
			end
			if (last) begin
				awaited_maps.push_back(locate_fields());
				clear_frame();
			end
		endfunction

		function void field_cmp(string name, int unsigned want, int unsigned seen);
			if (want != seen) begin
				errors++;
				$display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want,
					seen);
			end
		endfunction

		// Called for each result transfer out of the block.
		function void check_result(logic [OUT_W-1:0] data);
			res_t want;
			res_t seen;
			if (awaited_maps.size() == 0) begin
				errors++;
				$display("%0t: result with no frame pending: expected none, actual %h", $time,
					data);
				return;
			end
			want = awaited_maps.pop_front();
			seen = data[$bits(res_t)-1:0];
			field_cmp("status", want.status, seen.status);
			field_cmp("subj_offset", want.subj_offset, seen.subj_offset);
			field_cmp("subj_length", want.subj_length, seen.subj_length);
			field_cmp("sid_offset", want.sid_offset, seen.sid_offset);
			field_cmp("sid_len", want.sid_len, seen.sid_len);
			field_cmp("reply_present", want.reply_present, seen.reply_present);
			field_cmp("reply_offset", want.reply_offset, seen.reply_offset);
			field_cmp("reply_length", want.reply_length, seen.reply_length);
			field_cmp("body_offset", want.body_offset, seen.body_offset);
			field_cmp("body_length", want.body_length, seen.body_length);
			field_cmp("pad", 0, data[OUT_W-1:$bits(res_t)]);
		endfunction
	endclass

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata  = 8'h00;
	logic             s_tlast  = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	field_map_scoreboard sb;
	logic [7:0]          tx_bytes[$];
	int                  bytes_sent;
	bit                  hold_req    = 1'b0;
	bit                  hold_active = 1'b0;

	msg_frame_field_locator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Frame building: the bytes of the next frame collect in tx_bytes.
	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			tx_bytes.push_back(s[i]);
	endtask

	task automatic add_crlf();
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(CH_LF);
	endtask

	task automatic add_blanks(int n);
		repeat (n) tx_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
	endtask

	// Token bytes may be anything but a blank, CR or LF.
	task automatic add_token(int n);
		logic [7:0] b;
		repeat (n) begin
			do b = 8'($urandom);
			while (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF);
			tx_bytes.push_back(b);
		end
	endtask

	// Payload bytes avoid LF, except for a single one where with_lf asks for it.
	task automatic add_payload(int n, bit with_lf);
		logic [7:0] b;
		int         lf_at;
		lf_at = with_lf ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == lf_at) begin
				b = CH_LF;
			end else begin
				do b = 8'($urandom);
				while (b == CH_LF);
			end
			tx_bytes.push_back(b);
		end
	endtask

	task automatic build_frame(frame_kind_t kind, int subj_n, int sid_n, int reply_n,
		int pay_n);
		int size_val;
		int idx;
		tx_bytes.delete();
		if (kind == FR_NOISE) begin
			if ($urandom_range(0, 1))
				add_text("MSG");
			repeat ($urandom_range(1, 30)) tx_bytes.push_back(8'($urandom));
			return;
		end
		add_text("MSG");
		if (kind == FR_BAD_KEYWORD) begin
			idx = $urandom_range(0, 2);
			tx_bytes[idx] = tx_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		add_blanks($urandom_range(1, 3));
		add_token(subj_n);
		if (kind != FR_NO_SID) begin
			add_blanks($urandom_range(1, 3));
			add_token(sid_n);
		end
		if (reply_n > 0) begin
			add_blanks($urandom_range(1, 3));
			add_token(reply_n);
		end
		if (kind == FR_LF_IN_PAYLOAD && pay_n == 0)
			pay_n = 1;
		case (kind)
			FR_BAD_SIZE: size_val = (pay_n > 3 && $urandom_range(0, 1))
				? pay_n - $urandom_range(1, 3) : pay_n + $urandom_range(1, 3);
			FR_SIZE_OVER: size_val = $urandom_range(MAX_FRAME + 1, 99999);
			default: size_val = pay_n;
		endcase
		if (kind != FR_NO_BLANK_SIZE)
			add_blanks($urandom_range(1, 2));
		// An empty size field stands for zero; now and then leave the digits out.
		if (!(size_val == 0 && $urandom_range(0, 3) == 0)) begin
			if ($urandom_range(0, 7) == 0)
				tx_bytes.push_back(CH_0);
			add_text($sformatf("%0d", size_val));
		end
		if (kind == FR_NO_INNER_LF)
			tx_bytes.push_back(CH_CR);
		else
			add_crlf();
		add_payload(pay_n, kind == FR_LF_IN_PAYLOAD);
		if (kind == FR_BAD_TAIL) begin
			case ($urandom_range(0, 2))
				0: tx_bytes.push_back(CH_CR);
				1: tx_bytes.push_back(CH_LF);
				default: begin
					tx_bytes.push_back(CH_LF);
					tx_bytes.push_back(CH_CR);
				end
			endcase
		end else begin
			add_crlf();
		end
	endtask

	// Offers the bytes of tx_bytes one transfer at a time, with random gaps unless burst is set.
	task automatic send_frame(bit burst);
		int gap;
		int r;
		for (int i = 0; i < tx_bytes.size(); i++) begin
			r = $urandom_range(0, 99);
			if (burst || r < 60)
				gap = 0;
			else if (r < 90)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(5, 40);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= tx_bytes[i];
			s_tlast  <= (i == tx_bytes.size() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
		bytes_sent += tx_bytes.size();
	endtask

	// Both streams are watched at the clock edge; every input changes after it.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_byte(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Result side: random stalls, ready stretches, and one long hold-off on request.
	initial begin
		int r;
		int n;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_active = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					m_tready <= 1'b1;
					n = $urandom_range(1, 8);
				end else if (r < 65) begin
					m_tready <= 1'b1;
					n = $urandom_range(20, 80);
				end else if (r < 90) begin
					m_tready <= 1'b0;
					n = $urandom_range(1, 3);
				end else begin
					m_tready <= 1'b0;
					n = $urandom_range(10, 60);
				end
				repeat (n) @(posedge clk);
			end
		end
	end

	// Ends the run if neither stream moves for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		frame_kind_t kind;
		int          frames_sent;
		int          pay;
		sb = new();
		bytes_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest legal frame, empty payload.
		tx_bytes.delete();
		add_text("MSG a b 0");
		add_crlf();
		add_crlf();
		send_frame(1'b1);
		// Empty size field, tabs as blanks.
		tx_bytes.delete();
		add_text("MSG\tab\tc\t");
		add_crlf();
		add_crlf();
		send_frame(1'b0);
		// Too short.
		tx_bytes.delete();
		add_text("MSG a b");
		add_crlf();
		add_crlf();
		send_frame(1'b0);
		// A single byte frame.
		tx_bytes.delete();
		tx_bytes.push_back(8'hFF);
		send_frame(1'b0);
		// Reply-to token present.
		tx_bytes.delete();
		add_text("MSG\tfoo.bar 17  _INBOX.x 5");
		add_crlf();
		add_text("hello");
		add_crlf();
		send_frame(1'b0);
		// Size does not match the payload.
		tx_bytes.delete();
		add_text("MSG a b 3");
		add_crlf();
		add_text("hi");
		add_crlf();
		send_frame(1'b1);
		// Saturated size fields.
		tx_bytes.delete();
		add_text("MSG a b 99999");
		add_crlf();
		add_text("x");
		add_crlf();
		send_frame(1'b0);
		tx_bytes.delete();
		add_text("MSG a b 4097");
		add_crlf();
		add_crlf();
		send_frame(1'b0);
		// No LF before the closing CRLF.
		tx_bytes.delete();
		add_text("MSG a b c d e f g h");
		add_crlf();
		send_frame(1'b0);
		// Wrong keyword, and lower case.
		tx_bytes.delete();
		add_text("MSX a b 0");
		add_crlf();
		add_crlf();
		send_frame(1'b0);
		tx_bytes.delete();
		add_text("msg a b 0");
		add_crlf();
		add_crlf();
		send_frame(1'b0);
		// No blank after the sid.
		tx_bytes.delete();
		add_text("MSG subj 0");
		add_crlf();
		add_crlf();
		send_frame(1'b0);
		// Size digits with no blank in front.
		tx_bytes.delete();
		add_text("MSG a b c0");
		add_crlf();
		add_crlf();
		send_frame(1'b0);
		// Closing CRLF missing its LF.
		tx_bytes.delete();
		add_text("MSG a b 1");
		add_crlf();
		add_text("x");
		tx_bytes.push_back(CH_CR);
		send_frame(1'b0);
		// LF inside the payload.
		tx_bytes.delete();
		add_text("MSG a b 3");
		add_crlf();
		add_text("a");
		tx_bytes.push_back(CH_LF);
		add_text("b");
		add_crlf();
		send_frame(1'b0);
		// Leading zeros, and payload bytes at both extremes.
		tx_bytes.delete();
		add_text("MSG a b 002");
		add_crlf();
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		add_crlf();
		send_frame(1'b0);
		// Exactly MAX_FRAME bytes, then one byte more.
		tx_bytes.delete();
		add_text("MSG a b 4080");
		add_crlf();
		add_payload(4080, 1'b0);
		add_crlf();
		send_frame(1'b0);
		tx_bytes.delete();
		add_text("MSG a b 4081");
		add_crlf();
		add_payload(4081, 1'b0);
		add_crlf();
		send_frame(1'b1);

		// Hold the result side off while frames keep coming, so the input must stall.
		hold_req = 1'b1;
		wait (hold_active);
		repeat (6) begin
			build_frame(FR_GOOD, $urandom_range(1, 4), $urandom_range(1, 3), 0,
				$urandom_range(0, 6));
			send_frame(1'b1);
		end

		// Random frames, most of them well formed.
		bytes_sent  = 0;
		frames_sent = 0;
		while (bytes_sent < 950 || frames_sent < 40) begin
			kind = ($urandom_range(0, 99) < 65) ? FR_GOOD : frame_kind_t'($urandom_range(1, 9));
			pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
			build_frame(kind, $urandom_range(1, 6), $urandom_range(1, 4),
				$urandom_range(0, 1) ? $urandom_range(1, 6) : 0, pay);
			send_frame($urandom_range(0, 3) == 0);
			frames_sent++;
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (sb.awaited_maps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.awaited_maps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
